@@ rtl/qmn_pkg.sv @@
// Shared constants for the normalized quaternion product pipeline.
`timescale 1ns / 1ps
package qmn_pkg;
    // normalized magnitudes are aligned to this many bits
    localparam int MW = 30;
    // sum of squares width and root width
    localparam int SW = 2 * MW + 2;
    localparam int RW = MW + 1;
    // one root bit per sqrt stage
    localparam int SQ_STEPS = RW;
endpackage

@@ rtl/quaternion_multiply_normalize.sv @@
// Top level: pipelined Hamilton product with renormalization to unit length.
`timescale 1ns / 1ps
// Usage
//   Input channel: i_in_valid / o_in_ready carry both quaternions (Q2.14 by
//   default). Output channel: o_out_valid / i_out_ready carry the normalized
//   product and o_zero_norm. A transfer happens when valid and ready are high.
// Pipeline: 7 stages of multiply, sum, abs, bit length, alignment, squares
//   and sum of squares, 31 restoring square-root stages (one root bit
//   each), one setup stage, FRACTION_BITS+2 restoring divide stages with
//   four lanes, and the output register.
// Throughput: one item per cycle while i_out_ready is high. Every stage
//   has its own valid bit and loads whenever it is empty or its successor
//   loads, so bubbles close up.
// Stall: when i_out_ready is low the result holds; the pipe keeps taking
//   items until every stage is full, then o_in_ready drops. Nothing is lost
//   or repeated.
// Reset: synchronous, active low; clears all valid bits. The payload
//   registers are not reset.
// A product of exactly zero gives zero components and o_zero_norm high.
module quaternion_multiply_normalize
    import qmn_pkg::*;
#(
    parameter int COMPONENT_BITS = 16,
    parameter int FRACTION_BITS  = 14
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [COMPONENT_BITS-1:0] i_a_x,
    input  logic signed [COMPONENT_BITS-1:0] i_a_y,
    input  logic signed [COMPONENT_BITS-1:0] i_a_z,
    input  logic signed [COMPONENT_BITS-1:0] i_a_w,
    input  logic signed [COMPONENT_BITS-1:0] i_b_x,
    input  logic signed [COMPONENT_BITS-1:0] i_b_y,
    input  logic signed [COMPONENT_BITS-1:0] i_b_z,
    input  logic signed [COMPONENT_BITS-1:0] i_b_w,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [COMPONENT_BITS-1:0] o_r_x,
    output logic signed [COMPONENT_BITS-1:0] o_r_y,
    output logic signed [COMPONENT_BITS-1:0] o_r_z,
    output logic signed [COMPONENT_BITS-1:0] o_r_w,
    output logic                             o_zero_norm
);
    localparam int CB   = COMPONENT_BITS;
    localparam int FB   = FRACTION_BITS;
    localparam int PRW  = 2 * CB;          // one product
    localparam int SUMW = 2 * CB + 2;      // signed sum of four products
    localparam int PW   = 2 * CB + 1;      // magnitude of that sum
    localparam int LW   = $clog2(PW + 1);  // bit length of a magnitude
    localparam int QW   = FB + 2;          // quotient bits, one per divide stage
    localparam int NW   = MW + FB + 1;     // dividend
    localparam int EW   = ((QW > CB) ? QW : CB) + 1;
    // stage numbering of the valid bits
    localparam int ST_SQ  = 6;             // sum of squares = sqrt input
    localparam int ST_PRP = ST_SQ + SQ_STEPS + 1;
    localparam int ST_OUT = ST_PRP + QW + 1;
    localparam int NST    = ST_OUT + 1;
    localparam logic [EW-1:0] POS_LIM = EW'((64'd1 << (CB - 1)) - 64'd1);
    localparam logic [EW-1:0] NEG_LIM = EW'(64'd1 << (CB - 1));

    logic [NST-1:0] r_vld;
    logic [NST-1:0] take;

    // load when empty or when the next stage loads
    always_comb begin
        take[NST-1] = !r_vld[NST-1] || i_out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            take[k] = !r_vld[k] || take[k+1];
        end
    end

    assign o_in_ready  = take[0];
    assign o_out_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (take[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (take[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: sixteen products ----------------
    logic signed [PRW-1:0] r_p [4][4];
    always_ff @(posedge i_clk) begin
        if (take[0]) begin
            r_p[0][0] <= i_a_w * i_b_x;  r_p[0][1] <= i_a_x * i_b_w;
            r_p[0][2] <= i_a_y * i_b_z;  r_p[0][3] <= i_a_z * i_b_y;
            r_p[1][0] <= i_a_w * i_b_y;  r_p[1][1] <= i_a_y * i_b_w;
            r_p[1][2] <= i_a_z * i_b_x;  r_p[1][3] <= i_a_x * i_b_z;
            r_p[2][0] <= i_a_w * i_b_z;  r_p[2][1] <= i_a_z * i_b_w;
            r_p[2][2] <= i_a_x * i_b_y;  r_p[2][3] <= i_a_y * i_b_x;
            r_p[3][0] <= i_a_w * i_b_w;  r_p[3][1] <= i_a_x * i_b_x;
            r_p[3][2] <= i_a_y * i_b_y;  r_p[3][3] <= i_a_z * i_b_z;
        end
    end

    // ---------------- stage 1: component sums ----------------
    logic signed [SUMW-1:0] r_sum [4];
    always_ff @(posedge i_clk) begin
        if (take[1]) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= SUMW'(r_p[c][0]) + SUMW'(r_p[c][1])
                          + SUMW'(r_p[c][2]) - SUMW'(r_p[c][3]);
            end
            r_sum[3] <= SUMW'(r_p[3][0]) - SUMW'(r_p[3][1])
                      - SUMW'(r_p[3][2]) - SUMW'(r_p[3][3]);
        end
    end

    // ---------------- stage 2: sign and magnitude ----------------
    logic [PW-1:0] r_mag [4];
    logic [3:0]    r_neg2;
    always_ff @(posedge i_clk) begin
        if (take[2]) begin
            for (int c = 0; c < 4; c++) begin
                r_neg2[c] <= r_sum[c][SUMW-1];
                r_mag[c]  <= r_sum[c][SUMW-1] ? PW'(-r_sum[c]) : PW'(r_sum[c]);
            end
        end
    end

    // ---------------- stage 3: bit length of the largest magnitude ----------------
    // the OR of the magnitudes has the same bit length as their maximum
    logic [PW-1:0] or_mag;
    logic [LW-1:0] n_len;
    always_comb begin
        or_mag = r_mag[0] | r_mag[1] | r_mag[2] | r_mag[3];
        n_len  = '0;
        for (int i = 0; i < PW; i++) begin
            if (or_mag[i]) begin
                n_len = LW'(i + 1);
            end
        end
    end

    logic [PW-1:0] r_mag3 [4];
    logic [3:0]    r_neg3;
    logic [LW-1:0] r_len;
    always_ff @(posedge i_clk) begin
        if (take[3]) begin
            r_mag3 <= r_mag;
            r_neg3 <= r_neg2;
            r_len  <= n_len;
        end
    end

    // ---------------- stage 4: align so the largest lands in [2^29, 2^30) ----------------
    logic [MW-1:0] r_m4 [4];
    logic [3:0]    r_neg4;
    logic          r_zero4;
    always_ff @(posedge i_clk) begin
        if (take[4]) begin
            for (int c = 0; c < 4; c++) begin
                r_m4[c] <= MW'({r_mag3[c], {MW{1'b0}}} >> r_len);
            end
            r_neg4  <= r_neg3;
            r_zero4 <= (r_len == '0);
        end
    end

    // ---------------- stage 5: squares ----------------
    logic [2*MW-1:0] r_sqr [4];
    logic [MW-1:0]   r_m5 [4];
    logic [3:0]      r_neg5;
    logic            r_zero5;
    always_ff @(posedge i_clk) begin
        if (take[5]) begin
            for (int c = 0; c < 4; c++) begin
                r_sqr[c] <= (2*MW)'(r_m4[c]) * (2*MW)'(r_m4[c]);
            end
            r_m5    <= r_m4;
            r_neg5  <= r_neg4;
            r_zero5 <= r_zero4;
        end
    end

    // ---------------- stage 6 and sqrt stages ----------------
    // index 0 holds the sum of squares; index k+1 holds the result of root step k
    logic [SW-1:0]   r_qs   [SQ_STEPS+1];
    logic [RW+1:0]   r_qrem [SQ_STEPS+1];
    logic [RW-1:0]   r_qrt  [SQ_STEPS+1];
    logic [MW-1:0]   r_qm   [SQ_STEPS+1][4];
    logic [3:0]      r_qneg [SQ_STEPS+1];
    logic            r_qzero[SQ_STEPS+1];

    logic [RW+1:0]   rem_sh [SQ_STEPS];
    logic [RW+1:0]   trial  [SQ_STEPS];
    logic [SQ_STEPS-1:0] ge_sq;
    logic [RW+1:0]   n_qrem [SQ_STEPS];
    logic [RW-1:0]   n_qrt  [SQ_STEPS];

    // restoring square root, two radicand bits per step, top pair first
    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            rem_sh[k] = {r_qrem[k][RW-1:0], r_qs[k][2*(SQ_STEPS-1-k)+1 -: 2]};
            trial[k]  = {1'b0, r_qrt[k][RW-2:0], 2'b01};
            ge_sq[k]  = (rem_sh[k] >= trial[k]);
            n_qrem[k] = ge_sq[k] ? (rem_sh[k] - trial[k]) : rem_sh[k];
            n_qrt[k]  = {r_qrt[k][RW-2:0], ge_sq[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (take[ST_SQ]) begin
            r_qs[0]    <= SW'(r_sqr[0]) + SW'(r_sqr[1]) + SW'(r_sqr[2]) + SW'(r_sqr[3]);
            r_qrem[0]  <= '0;
            r_qrt[0]   <= '0;
            r_qm[0]    <= r_m5;
            r_qneg[0]  <= r_neg5;
            r_qzero[0] <= r_zero5;
        end
        for (int k = 0; k < SQ_STEPS; k++) begin
            if (take[ST_SQ+1+k]) begin
                r_qs[k+1]    <= r_qs[k];
                r_qrem[k+1]  <= n_qrem[k];
                r_qrt[k+1]   <= n_qrt[k];
                r_qm[k+1]    <= r_qm[k];
                r_qneg[k+1]  <= r_qneg[k];
                r_qzero[k+1] <= r_qzero[k];
            end
        end
    end

    // ---------------- divide setup and divide stages ----------------
    // dividend = m * 2^FB + floor(q/2); index 0 is the setup stage
    logic [NW-1:0] r_dn   [QW+1][4];
    logic [RW-1:0] r_drem [QW+1][4];
    logic [QW-1:0] r_dquo [QW+1][4];
    logic [RW-1:0] r_dq   [QW+1];
    logic [3:0]    r_dneg [QW+1];
    logic          r_dzero[QW+1];

    logic [NW-1:0] n_dn [4];
    logic [RW:0]   drem2 [QW][4];
    logic          dge   [QW][4];
    logic [RW-1:0] n_drem [QW][4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_dn[c] = NW'({r_qm[SQ_STEPS][c], {FB{1'b0}}})
                    + NW'(r_qrt[SQ_STEPS] >> 1);
        end
        for (int j = 0; j < QW; j++) begin
            for (int c = 0; c < 4; c++) begin
                drem2[j][c]  = {r_drem[j][c], r_dn[j][c][QW-1-j]};
                dge[j][c]    = (drem2[j][c] >= {1'b0, r_dq[j]});
                n_drem[j][c] = dge[j][c] ? RW'(drem2[j][c] - {1'b0, r_dq[j]})
                                         : RW'(drem2[j][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take[ST_PRP]) begin
            for (int c = 0; c < 4; c++) begin
                r_dn[0][c]   <= n_dn[c];
                r_drem[0][c] <= RW'(n_dn[c] >> QW);
                r_dquo[0][c] <= '0;
            end
            r_dq[0]    <= r_qrt[SQ_STEPS];
            r_dneg[0]  <= r_qneg[SQ_STEPS];
            r_dzero[0] <= r_qzero[SQ_STEPS];
        end
        for (int j = 0; j < QW; j++) begin
            if (take[ST_PRP+1+j]) begin
                for (int c = 0; c < 4; c++) begin
                    r_dn[j+1][c]   <= r_dn[j][c];
                    r_drem[j+1][c] <= n_drem[j][c];
                    r_dquo[j+1][c] <= {r_dquo[j][c][QW-2:0], dge[j][c]};
                end
                r_dq[j+1]    <= r_dq[j];
                r_dneg[j+1]  <= r_dneg[j];
                r_dzero[j+1] <= r_dzero[j];
            end
        end
    end

    // ---------------- output stage: sign, saturation, zero case ----------------
    logic [EW-1:0] qx [4];
    logic [CB-1:0] n_res [4];
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            qx[c] = EW'(r_dquo[QW][c]);
            if (r_dzero[QW]) begin
                n_res[c] = '0;
            end else if (r_dneg[QW][c]) begin
                n_res[c] = CB'(-((qx[c] > NEG_LIM) ? NEG_LIM : qx[c]));
            end else begin
                n_res[c] = CB'((qx[c] > POS_LIM) ? POS_LIM : qx[c]);
            end
        end
    end

    logic [CB-1:0] r_res [4];
    logic          r_zero_out;
    always_ff @(posedge i_clk) begin
        if (take[ST_OUT]) begin
            r_res      <= n_res;
            r_zero_out <= r_dzero[QW];
        end
    end

    assign o_r_x       = r_res[0];
    assign o_r_y       = r_res[1];
    assign o_r_z       = r_res[2];
    assign o_r_w       = r_res[3];
    assign o_zero_norm = r_zero_out;

endmodule

@@ rtl/qmn_checker.sv @@
// Port-level assertions for the normalized quaternion product, with bind.
`timescale 1ns / 1ps
module qmn_checker #(
    parameter int COMPONENT_BITS = 16
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [COMPONENT_BITS-1:0] o_r_x,
    input logic [COMPONENT_BITS-1:0] o_r_y,
    input logic [COMPONENT_BITS-1:0] o_r_z,
    input logic [COMPONENT_BITS-1:0] o_r_w,
    input logic                      o_zero_norm
);
    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // pipe is empty right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("valid result right after reset");

    // zero product gives zero components
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_norm |->
            o_r_x == '0 && o_r_y == '0 && o_r_z == '0 && o_r_w == '0)
        else $error("zero product with nonzero components");

    // a unit-length result cannot be all zeros
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_zero_norm |->
            o_r_x != '0 || o_r_y != '0 || o_r_z != '0 || o_r_w != '0)
        else $error("normalized result is all zeros");
endmodule

bind quaternion_multiply_normalize qmn_checker #(
    .COMPONENT_BITS(COMPONENT_BITS)
) u_qmn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_r_x       (o_r_x),
    .o_r_y       (o_r_y),
    .o_r_z       (o_r_z),
    .o_r_w       (o_r_w),
    .o_zero_norm (o_zero_norm)
);
